FILE: sv/mm3_pkg.sv
package mm3_pkg;

	localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] MM_N1 = 64'h0000000052dce729;
	localparam logic [63:0] MM_N2 = 64'h0000000038495ab5;
	localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] MM_KEY_BYTES = 64'd16;

	// body (10) + finalizer (5) + output cross-add (2)
	localparam int PIPE_DEPTH = 17;

	// APB: one 32-bit register at byte address 0; paddr[2] selects the register index
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic REG_HASH_SEED = 1'b0;

	typedef struct packed {
		logic [63:0] key_low;
		logic [63:0] key_high;
	} mm3_key_t;

	typedef struct packed {
		logic [63:0] hash_low;
		logic [63:0] hash_high;
	} mm3_hash_t;

	// rotate left by a constant amount, 1..63
	function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
		return (v << n) | (v >> (64 - n));
	endfunction

	// v * 5 as shift and add
	function automatic logic [63:0] times5(input logic [63:0] v);
		return (v << 2) + v;
	endfunction

endpackage

FILE: sv/murmur3_128_hash.sv
// murmur3_128_hash: MurmurHash3 x64 128-bit hash of one 16-byte key per word.
//
// Input channel (key_valid / key_stall / key): one word carries the key as two
// little-endian 64-bit halves. Output channel (hash_valid / hash_stall / hash):
// one word per key, the two 64-bit hash halves, in key order.
// The seed sits in an APB register at byte address 0 (32 bits, reads back).
// Write it only while no key is in flight.
//
// Timing: 17-stage pipeline (four 64x64 multiplies in series on each lane, each split
// into 32x32 partials and a combine stage, plus lane adds). One key per cycle
// sustained while the output is not stalled.
//
// Stall: the whole pipe advances together whenever the output register is
// empty or being taken. While hash_stall holds a valid word, everything
// freezes, hash stays put and key_stall is raised; nothing is dropped.
// Reset: all valid bits cleared, seed back to zero.
module murmur3_128_hash (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mm3_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [mm3_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [mm3_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready,
	input  logic                             key_valid,
	output logic                             key_stall,
	input  mm3_pkg::mm3_key_t                key,
	output logic                             hash_valid,
	input  logic                             hash_stall,
	output mm3_pkg::mm3_hash_t               hash
);
	import mm3_pkg::*;

	logic                  adv;
	logic [PIPE_DEPTH-1:0] vld_q;
	logic [31:0]           seed_q;
	logic                  cfg_wr;

	logic [63:0] h1, h2;
	logic [63:0] f1, f2;
	logic [63:0] o1_s16, f2_s16;
	mm3_hash_t   hash_s17;

	// ---- config port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_HASH_SEED) ? seed_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr && paddr[2] == REG_HASH_SEED) begin
			seed_q <= pwdata[31:0];
		end
	end

	// ---- flow control: one enable for the whole pipe ----
	assign adv        = !hash_valid || !hash_stall;
	assign key_stall  = !adv;
	assign hash_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], key_valid};
		end
	end

	// ---- datapath ----
	// s1..s10: body mixing, length fold, first cross-add
	mm3_body u_body (
		.clk  (clk),
		.en   (adv),
		.seed (seed_q),
		.key  (key),
		.h1   (h1),
		.h2   (h2)
	);

	// s11..s15: fmix64 on each lane
	mm3_fmix u_fmix1 (.clk(clk), .en(adv), .v(h1), .f(f1));
	mm3_fmix u_fmix2 (.clk(clk), .en(adv), .v(h2), .f(f2));

	// s16..s17: final cross-add, lane one then lane two
	always_ff @(posedge clk) begin
		if (adv) begin
			o1_s16             <= f1 + f2;
			f2_s16             <= f2;
			hash_s17.hash_low  <= o1_s16;
			hash_s17.hash_high <= f2_s16 + o1_s16;
		end
	end

	assign hash = hash_s17;

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		key_stall == (hash_valid && hash_stall))
		else $error("key_stall does not match output backpressure");

	a_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!key_stall |=> vld_q[0] == $past(key_valid))
		else $error("accepted key not tracked in stage one");

	a_frozen_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		key_stall |=> $stable(vld_q))
		else $error("valid bits moved while stalled");

	a_seed_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && paddr[2] == REG_HASH_SEED) |=> seed_q == $past(pwdata[31:0]))
		else $error("seed register write lost");
`endif

endmodule

FILE: sv/mm3_mul64.sv
// 64x64 multiply, low 64 bits of the product, two stages.
// Stage 1: three 32x32 partial products; stage 2: combine.
module mm3_mul64 (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_c;
	logic [31:0] lh_c, hl_c;
	logic [63:0] ll_s1;
	logic [31:0] lh_s1, hl_s1;
	logic [63:0] p_s2;

	// cross terms only feed the upper half, so their low 32 bits suffice
	always_comb begin
		ll_c = 64'(a[31:0]) * 64'(b[31:0]);
		lh_c = a[31:0] * b[63:32];
		hl_c = a[63:32] * b[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= ll_c;
			lh_s1 <= lh_c;
			hl_s1 <= hl_c;
			p_s2  <= ll_s1 + {lh_s1 + hl_s1, 32'h0000_0000};
		end
	end

	assign p = p_s2;

endmodule

FILE: sv/mm3_body.sv
// Body block mixing of both lanes plus the length fold and first cross-add.
// Ten stages: two multiplies per key word (s1..s4), then lane arithmetic (s5..s10).
module mm3_body (
	input  logic              clk,
	input  logic              en,
	input  logic [31:0]       seed,
	input  mm3_pkg::mm3_key_t key,
	output logic [63:0]       h1,
	output logic [63:0]       h2
);
	import mm3_pkg::*;

	logic [63:0] seed64;
	logic [63:0] w1a, w2a, w1b, w2b;
	logic [63:0] l1a_s5, x2_s5;
	logic [63:0] l1_s6, x2_s6;
	logic [63:0] l1_s7, l2a_s7;
	logic [63:0] l1_s8, l2_s8;
	logic [63:0] h1_s9, l2x_s9;
	logic [63:0] h1_s10, h2_s10;

	assign seed64 = {32'h0000_0000, seed};

	mm3_mul64 u_mul_k1a (.clk(clk), .en(en), .a(key.key_low),  .b(MM_C1), .p(w1a));
	mm3_mul64 u_mul_k2a (.clk(clk), .en(en), .a(key.key_high), .b(MM_C2), .p(w2a));
	mm3_mul64 u_mul_k1b (.clk(clk), .en(en), .a(rotl64(w1a, 31)), .b(MM_C2), .p(w1b));
	mm3_mul64 u_mul_k2b (.clk(clk), .en(en), .a(rotl64(w2a, 33)), .b(MM_C1), .p(w2b));

	// seed is read live, so the user must see that it changes only while the pipe is empty; the block does not enforce it
	always_ff @(posedge clk) begin
		if (en) begin
			l1a_s5 <= rotl64(seed64 ^ w1b, 27) + seed64;
			x2_s5  <= rotl64(seed64 ^ w2b, 31);

			l1_s6  <= times5(l1a_s5) + MM_N1;
			x2_s6  <= x2_s5;

			l2a_s7 <= x2_s6 + l1_s6;
			l1_s7  <= l1_s6;

			l2_s8  <= times5(l2a_s7) + MM_N2;
			l1_s8  <= l1_s7;

			h1_s9  <= (l1_s8 ^ MM_KEY_BYTES) + (l2_s8 ^ MM_KEY_BYTES);
			l2x_s9 <= l2_s8 ^ MM_KEY_BYTES;

			h1_s10 <= h1_s9;
			h2_s10 <= l2x_s9 + h1_s9;
		end
	end

	assign h1 = h1_s10;
	assign h2 = h2_s10;

endmodule

FILE: sv/mm3_fmix.sv
// fmix64 finalizer, five stages: two pipelined multiplies and a final xor-shift.
module mm3_fmix (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	output logic [63:0] f
);
	import mm3_pkg::*;

	logic [63:0] p1, p2;
	logic [63:0] f_s5;

	mm3_mul64 u_mul_f1 (.clk(clk), .en(en), .a(v ^ (v >> 33)),   .b(MM_F1), .p(p1));
	mm3_mul64 u_mul_f2 (.clk(clk), .en(en), .a(p1 ^ (p1 >> 33)), .b(MM_F2), .p(p2));

	always_ff @(posedge clk) begin
		if (en) begin
			f_s5 <= p2 ^ (p2 >> 33);
		end
	end

	assign f = f_s5;

endmodule

FILE: bench/tb_murmur3_128_hash.sv
`timescale 1ns / 100ps

// Testbench for murmur3_128_hash: 128-bit MurmurHash3 (x64) of one 16-byte key per word.
//
// Keys go in on the key channel (valid/stall). A local copy of the hash
// computes the expected 128-bit result as each key is accepted and queues
// it. A checker process compares every hash word that leaves the block,
// field by field, against the oldest queued hash.
// The seed register is written over APB only while nothing is in flight.
// The sequence of tests:
//   - reset value of the seed, extreme and patterned keys
//   - extreme seeds, with readback
//   - a write to an index with no register behind it (must be ignored)
//   - a long output hold-off that fills the pipe and stalls the input
//   - random keys over several seed settings, with random gaps on both sides
module tb_murmur3_128_hash;
	import mm3_pkg::*;

	localparam int CLK_HALF = 5;
	localparam int CYCLE_LIMIT = 400000;
	localparam int KEYS_PER_PHASE = 100;
	localparam int RANDOM_PHASES = 5;
	localparam int HOLDOFF_LEN = 300;
	// index 1 has no register behind it; writes there must be dropped
	localparam int unsigned REG_OUT_OF_RANGE = 1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;
	logic key_valid = 1'b0;
	logic key_stall;
	mm3_key_t key = '0;
	logic hash_valid;
	logic hash_stall = 1'b0;
	mm3_hash_t hash;

	// local copy of the seed register, updated on every write to the seed index
	logic [31:0] seed_shadow = '0;
	// hashes that the block still owes us, oldest first
	mm3_hash_t pending_hashes[$];

	int mismatch_count = 0;
	int hashes_checked = 0;
	int seed_writes = 0;
	int cycle_count = 0;

	// stimulus knobs, set from the test tasks
	bit tx_gaps_on = 1'b0;
	bit rx_stalls_on = 1'b0;
	int holdoff_cycles = 0;
	int stall_left = 0;

	murmur3_128_hash dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.key_valid  (key_valid),
		.key_stall  (key_stall),
		.key        (key),
		.hash_valid (hash_valid),
		.hash_stall (hash_stall),
		.hash       (hash)
	);

	always #CLK_HALF clk = ~clk;

	// ---------------------------------------------------------------
	// Hash predictor
	// ---------------------------------------------------------------

	// rotate taken as a window out of the word doubled up
	function automatic logic [63:0] rotate_left(input logic [63:0] v, input int unsigned n);
		logic [127:0] doubled;
		doubled = {v, v};
		return doubled[(127 - n) -: 64];
	endfunction

	// fmix64 finalizer
	function automatic logic [63:0] avalanche(input logic [63:0] v);
		logic [63:0] x;
		x = v;
		x = x ^ (x >> 33);
		x = x * MM_F1;
		x = x ^ (x >> 33);
		x = x * MM_F2;
		x = x ^ (x >> 33);
		return x;
	endfunction

	// one body block of 16 bytes, no tail, length 16
	function automatic mm3_hash_t murmur_hash_of(input logic [31:0] seed, input mm3_key_t k);
		logic [63:0] lane_a;
		logic [63:0] lane_b;
		logic [63:0] word_a;
		logic [63:0] word_b;
		mm3_hash_t h;
		lane_a = {32'd0, seed};
		lane_b = {32'd0, seed};

		word_a = k.key_low * MM_C1;
		word_a = rotate_left(word_a, 31);
		word_a = word_a * MM_C2;
		lane_a = rotate_left(lane_a ^ word_a, 27);
		lane_a = lane_a + lane_b;
		lane_a = lane_a * 64'd5 + MM_N1;

		// lane two mixes after lane one has already moved on
		word_b = k.key_high * MM_C2;
		word_b = rotate_left(word_b, 33);
		word_b = word_b * MM_C1;
		lane_b = rotate_left(lane_b ^ word_b, 31);
		lane_b = lane_b + lane_a;
		lane_b = lane_b * 64'd5 + MM_N2;

		lane_a = lane_a ^ MM_KEY_BYTES;
		lane_b = lane_b ^ MM_KEY_BYTES;
		lane_a = lane_a + lane_b;
		lane_b = lane_b + lane_a;
		lane_a = avalanche(lane_a);
		lane_b = avalanche(lane_b);
		lane_a = lane_a + lane_b;
		lane_b = lane_b + lane_a;

		h.hash_low = lane_a;
		h.hash_high = lane_b;
		return h;
	endfunction

	// ---------------------------------------------------------------
	// Shared helpers
	// ---------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("[%0t] MISMATCH %s: expected %h, got %h", $time, what, want, got);
		mismatch_count++;
	endtask

	// mostly short gaps, now and then a long one
	function automatic int rand_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled)
			return 0;
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// random key half with some weight on corner patterns
	function automatic logic [63:0] rand_key_half();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return 64'd0;
			1: return '1;
			2: return 64'd1 << $urandom_range(0, 63);
			3: return ~(64'd1 << $urandom_range(0, 63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Offer one key word and wait for it to be taken. Called right after a
	// rising edge. With gap 0 valid stays up, so the caller must follow
	// with another send or with drain_hashes in the same step.
	task automatic send_key(input logic [63:0] low, input logic [63:0] high, input int gap);
		mm3_key_t k;
		k.key_low = low;
		k.key_high = high;
		key <= k;
		key_valid <= 1'b1;
		do
			@(posedge clk);
		while (key_stall);
		pending_hashes.push_back(murmur_hash_of(seed_shadow, k));
		if (gap > 0) begin
			key_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait for every owed hash to come out
	task automatic drain_hashes();
		key_valid <= 1'b0;
		while (pending_hashes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready, then back to idle
	task automatic cfg_write(input int unsigned reg_index, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= CFG_ADDR_W'(reg_index << 2);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_index == REG_HASH_SEED) begin
			seed_shadow = value;
			seed_writes++;
		end
		@(posedge clk);
	endtask

	task automatic cfg_read(input int unsigned reg_index, output logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		paddr <= CFG_ADDR_W'(reg_index << 2);
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_seed_readback();
		logic [31:0] rd;
		cfg_read(REG_HASH_SEED, rd);
		if (rd !== seed_shadow)
			report_mismatch("seed readback", {32'd0, seed_shadow}, {32'd0, rd});
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// seed straight out of reset, corner keys back to back and with gaps
	task automatic test_reset_seed();
		check_seed_readback();
		send_key(64'd0, 64'd0, 0);
		send_key('1, '1, 0);
		send_key('1, 64'd0, 1);
		send_key(64'd0, '1, 0);
		send_key(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 2);
		send_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 0);
		send_key(64'h8000000000000000, 64'd1, 0);
		send_key(64'd1, 64'h8000000000000000, 0);
		drain_hashes();
	endtask

	// largest, smallest nonzero and top-bit-only seeds
	task automatic test_seed_extremes();
		cfg_write(REG_HASH_SEED, 32'hffffffff);
		check_seed_readback();
		send_key(64'd0, 64'd0, 0);
		send_key('1, '1, 0);
		send_key(64'h0123456789abcdef, 64'hfedcba9876543210, 0);
		drain_hashes();
		cfg_write(REG_HASH_SEED, 32'h00000001);
		check_seed_readback();
		send_key(64'd0, 64'd0, 3);
		drain_hashes();
		cfg_write(REG_HASH_SEED, 32'h80000000);
		check_seed_readback();
		send_key('1, 64'd0, 0);
		send_key(64'd0, '1, 0);
		drain_hashes();
	endtask

	// a write to an unmapped index must leave the seed alone
	task automatic test_unmapped_write();
		cfg_write(REG_HASH_SEED, 32'h1234abcd);
		cfg_write(REG_OUT_OF_RANGE, 32'hdeadbeef);
		check_seed_readback();
		send_key(64'hdeadbeefdeadbeef, 64'h0, 0);
		send_key(64'h0f0f0f0f0f0f0f0f, 64'hf0f0f0f0f0f0f0f0, 0);
		drain_hashes();
	endtask

	// Output held off for a long stretch while keys keep coming: the pipe
	// fills, key_stall must rise, and nothing may be lost or reordered.
	task automatic test_output_holdoff();
		int i;
		holdoff_cycles = HOLDOFF_LEN;
		for (i = 0; i < 40; i++)
			send_key(rand_key_half(), rand_key_half(), 0);
		drain_hashes();
	endtask

	// random keys, one seed per phase; first phase runs with no idling at all
	task automatic test_random_keys();
		int phase;
		int i;
		logic [31:0] seed;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: seed = 32'd0;
				1: seed = 32'hffffffff;
				default: seed = $urandom;
			endcase
			cfg_write(REG_HASH_SEED, seed);
			tx_gaps_on = (phase != 0);
			rx_stalls_on = (phase != 0);
			for (i = 0; i < KEYS_PER_PHASE; i++)
				send_key(rand_key_half(), rand_key_half(), rand_gap(tx_gaps_on));
			drain_hashes();
		end
		rx_stalls_on = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// Receiver: random stalls plus the long hold-off, counted here
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (holdoff_cycles > 0) begin
			hash_stall <= 1'b1;
			holdoff_cycles--;
		end else if (stall_left > 0) begin
			hash_stall <= 1'b1;
			stall_left--;
		end else if (rx_stalls_on && $urandom_range(0, 99) < 25) begin
			hash_stall <= 1'b1;
			stall_left = rand_gap(1'b1);
		end else begin
			hash_stall <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Checker: every hash word taken is matched against the oldest owed one
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		mm3_hash_t owed;
		if (arst_n && hash_valid && !hash_stall) begin
			if (pending_hashes.size() == 0) begin
				report_mismatch("unexpected hash_low", 64'd0, hash.hash_low);
			end else begin
				owed = pending_hashes.pop_front();
				if (hash.hash_low !== owed.hash_low)
					report_mismatch("hash_low", owed.hash_low, hash.hash_low);
				if (hash.hash_high !== owed.hash_high)
					report_mismatch("hash_high", owed.hash_high, hash.hash_high);
				hashes_checked++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d hashes still owed",
				cycle_count, pending_hashes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_seed();
		test_seed_extremes();
		test_unmapped_write();
		test_output_holdoff();
		test_random_keys();

		// catch anything extra trailing out of the pipe
		repeat (PIPE_DEPTH + 8) @(posedge clk);

		$display("Checked %0d hashes across %0d seed writes, with a %0d-cycle output hold-off",
			hashes_checked, seed_writes, HOLDOFF_LEN);
		$display("and random gaps and stalls on both channels; %0d mismatches", mismatch_count);
		if (mismatch_count == 0 && pending_hashes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/mm3_pkg.sv
sv/mm3_mul64.sv
sv/mm3_body.sv
sv/mm3_fmix.sv
sv/murmur3_128_hash.sv
bench/tb_murmur3_128_hash.sv
